/* design/sorted_channel_map_lookup_core_defines.svh */
// assertion macros shared by the sorted channel map lookup design
// no dependencies; included by files that carry concurrent assertions
`ifndef SORTED_CHANNEL_MAP_LOOKUP_CORE_DEFINES_SVH
`define SORTED_CHANNEL_MAP_LOOKUP_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SCML_ASSERT_IMPL(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("scml assertion failed");

// antecedent implies consequent in the next cycle
`define SCML_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("scml assertion failed");

// condition holds at every edge outside reset
`define SCML_ASSERT_ALWAYS(label, ck, rs, cond) \
  `SCML_ASSERT_IMPL(label, ck, rs, 1'b1, cond)

`else

`define SCML_ASSERT_IMPL(label, ck, rs, ante, cons)
`define SCML_ASSERT_NEXT(label, ck, rs, ante, cons)
`define SCML_ASSERT_ALWAYS(label, ck, rs, cond)

`endif

`endif

/* design/scml_pkg.sv */
// types and constants for the sorted channel map lookup
// no dependencies; used by the interfaces, the cell and the top level
package scml_pkg;

  localparam int KEY_W     = 32;
  localparam int NAME_W    = 32;
  localparam int PLANE_W   = 16;
  localparam int SEG_W     = 8;
  localparam int CHAN_W    = 32;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int RANK_W    = 10;
  localparam int COUNT_W   = 11;

  // item kinds on the request channel
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // operation a token performs while walking the chain
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_LOAD = 2'd1,
    OP_FIND = 2'd2
  } op_t;

  // detector record
  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [PLANE_W-1:0] plane;
    logic [SEG_W-1:0]   segment;
    logic [CHAN_W-1:0]  channel;
  } rec_t;

  // one table entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    rec_t             rec;
  } entry_t;

  // token handed from cell to cell
  typedef struct packed {
    logic    valid;
    op_t     op;
    logic    hit;
    status_t status;
    entry_t  ent;
  } tok_t;

endpackage

/* design/scml_if.sv */
// request and response channel interfaces of the sorted channel map lookup
// depends on scml_pkg for field widths
interface scml_req_if;
  logic                         valid;
  logic                         ready;
  logic [scml_pkg::KIND_W-1:0]  kind;
  logic [7:0]                   ip_third;
  logic [7:0]                   ip_fourth;
  logic [15:0]                  fe_chan;
  logic [scml_pkg::NAME_W-1:0]  rec_name;
  logic [scml_pkg::PLANE_W-1:0] rec_plane;
  logic [scml_pkg::SEG_W-1:0]   rec_segment;
  logic [scml_pkg::CHAN_W-1:0]  rec_channel;

  modport source (
    output valid, kind, ip_third, ip_fourth, fe_chan,
    output rec_name, rec_plane, rec_segment, rec_channel,
    input  ready
  );
  modport sink (
    input  valid, kind, ip_third, ip_fourth, fe_chan,
    input  rec_name, rec_plane, rec_segment, rec_channel,
    output ready
  );
endinterface

interface scml_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [scml_pkg::STATUS_W-1:0] status;
  logic [scml_pkg::RANK_W-1:0]   rank;
  logic [scml_pkg::NAME_W-1:0]   out_name;
  logic [scml_pkg::PLANE_W-1:0]  out_plane;
  logic [scml_pkg::SEG_W-1:0]    out_segment;
  logic [scml_pkg::CHAN_W-1:0]   out_channel;
  logic [scml_pkg::COUNT_W-1:0]  entry_count;

  modport source (
    output valid, status, rank, out_name, out_plane, out_segment, out_channel,
    output entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, rank, out_name, out_plane, out_segment, out_channel,
    input  entry_count,
    output ready
  );
endinterface

/* design/scml_cell.sv */
// one cell of the sorted chain: holds a single table entry at a fixed rank
// depends on scml_pkg for the entry and token types
module scml_cell #(
  parameter int IDX = 0,
  parameter int IW  = 10,
  parameter int CW  = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  scml_pkg::tok_t   tok_in,
  input  logic [CW-1:0]    cnt_in,
  input  logic [IW-1:0]    rank_in,
  output scml_pkg::tok_t   tok_out,
  output logic [CW-1:0]    cnt_out,
  output logic [IW-1:0]    rank_out
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [IW-1:0] IDX_R = IW'(IDX);

  scml_pkg::entry_t held;
  scml_pkg::entry_t held_next;
  scml_pkg::tok_t   tok_next;
  logic [IW-1:0]    rank_next;
  logic             wr;
  logic             below_cnt;
  logic             upto_cnt;

  // cell holds a live entry when its rank is below the token's count
  assign below_cnt = (IDX_C < cnt_in);
  assign upto_cnt  = (IDX_C <= cnt_in);

  // insert, shift or match against the held entry
  always_comb begin
    tok_next  = tok_in;
    rank_next = rank_in;
    held_next = held;
    wr        = 1'b0;
    if (tok_in.valid) begin
      case (tok_in.op)
        scml_pkg::OP_LOAD: begin
          if (!tok_in.hit) begin
            // new entry goes after every equal key
            if (!below_cnt || (held.key > tok_in.ent.key)) begin
              wr           = 1'b1;
              held_next    = tok_in.ent;
              tok_next.ent = held;
              tok_next.hit = 1'b1;
              rank_next    = IDX_R;
            end
          end else if (upto_cnt) begin
            // shift the displaced entry one place up
            wr           = 1'b1;
            held_next    = tok_in.ent;
            tok_next.ent = held;
          end
        end
        scml_pkg::OP_FIND: begin
          if (!tok_in.hit && below_cnt && (held.key == tok_in.ent.key)) begin
            tok_next.hit = 1'b1;
            tok_next.ent = held;
            rank_next    = IDX_R;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (advance && wr) begin
      held <= held_next;
    end
  end

  // token toward the next cell, only its valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out.valid <= tok_next.valid;
    end
    if (advance) begin
      tok_out.op     <= tok_next.op;
      tok_out.hit    <= tok_next.hit;
      tok_out.status <= tok_next.status;
      tok_out.ent    <= tok_next.ent;
      cnt_out        <= cnt_in;
      rank_out       <= rank_next;
    end
  end

endmodule

/* design/sorted_channel_map_lookup_core.sv */
// top level of the sorted channel map lookup: fill count, cell chain, result register
// depends on scml_pkg, scml_if, scml_cell and the assertion macro header
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+-----------------------------------------------
//   req     | in  | valid/ready  | kind, key octets and channel, detector record
//   rsp     | out | valid/ready  | status, rank, matched record, entry_count
//
// an item walks the chain one cell per cycle while the chain advances: it passes
// through the cell registers and then the result register, and a new item is taken
// every cycle while the result register drains
// the chain and the request side stall together when a result waits untaken
// reset clears the fill count and every token valid; entries need no clearing
// since a cell is live only when its rank is below the count carried by the item

`include "sorted_channel_map_lookup_core_defines.svh"

module sorted_channel_map_lookup_core #(
  parameter int ENTRIES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  scml_req_if.sink   req,
  scml_rsp_if.source rsp
);

  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int IW      = $clog2(ENTRIES);
  localparam int RANK_W  = scml_pkg::RANK_W;
  localparam int COUNT_W = scml_pkg::COUNT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  logic           advance;
  logic           acc;
  logic [CW-1:0]  fill_count;
  logic [CW-1:0]  fill_count_next;

  scml_pkg::tok_t tok [ENTRIES+1];
  logic [CW-1:0]  cnt [ENTRIES+1];
  logic [IW-1:0]  rnk [ENTRIES+1];

  scml_pkg::tok_t tok_last;
  logic           last_load;
  logic           last_found;

  // chain moves whenever the result register is empty or being taken
  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance;
  assign acc       = req.valid && advance;

  // build the entering token and the next fill count
  always_comb begin
    tok[0].valid               = acc;
    tok[0].op                  = scml_pkg::OP_NONE;
    tok[0].hit                 = 1'b0;
    tok[0].status              = scml_pkg::ST_OK;
    tok[0].ent.key             = {req.ip_third, req.ip_fourth, req.fe_chan};
    tok[0].ent.rec.name        = req.rec_name;
    tok[0].ent.rec.plane       = req.rec_plane;
    tok[0].ent.rec.segment     = req.rec_segment;
    tok[0].ent.rec.channel     = req.rec_channel;
    cnt[0]                     = fill_count;
    fill_count_next            = fill_count;
    case (scml_pkg::kind_t'(req.kind))
      scml_pkg::KIND_CLEAR: begin
        cnt[0] = '0;
        if (acc) begin
          fill_count_next = '0;
        end
      end
      scml_pkg::KIND_LOAD: begin
        if (fill_count == FULL_CNT) begin
          tok[0].status = scml_pkg::ST_FULL;
        end else begin
          tok[0].op = scml_pkg::OP_LOAD;
          if (acc) begin
            fill_count_next = fill_count + CW'(1);
          end
        end
      end
      scml_pkg::KIND_LOOKUP: begin
        tok[0].op = scml_pkg::OP_FIND;
      end
      default: begin
      end
    endcase
  end

  assign rnk[0] = '0;

  // fill count register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  // row of cells, rank g held in cell g
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    scml_cell #(
      .IDX (g),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .tok_in   (tok[g]),
      .cnt_in   (cnt[g]),
      .rank_in  (rnk[g]),
      .tok_out  (tok[g+1]),
      .cnt_out  (cnt[g+1]),
      .rank_out (rnk[g+1])
    );
  end

  assign tok_last   = tok[ENTRIES];
  assign last_load  = (tok_last.op == scml_pkg::OP_LOAD);
  assign last_found = (tok_last.op == scml_pkg::OP_FIND) && tok_last.hit;

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= tok_last.valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance && tok_last.valid) begin
      if (tok_last.op == scml_pkg::OP_FIND) begin
        rsp.status <= tok_last.hit ? scml_pkg::ST_OK : scml_pkg::ST_MISS;
      end else begin
        rsp.status <= tok_last.status;
      end
      rsp.rank        <= (last_load || last_found) ? RANK_W'(rnk[ENTRIES]) : '0;
      rsp.out_name    <= last_found ? tok_last.ent.rec.name : '0;
      rsp.out_plane   <= last_found ? tok_last.ent.rec.plane : '0;
      rsp.out_segment <= last_found ? tok_last.ent.rec.segment : '0;
      rsp.out_channel <= last_found ? tok_last.ent.rec.channel : '0;
      rsp.entry_count <= COUNT_W'(cnt[ENTRIES]) + COUNT_W'(last_load);
    end
  end

  // checks
  `SCML_ASSERT_ALWAYS(a_fill_bound, clk, rst, fill_count <= FULL_CNT)
  `SCML_ASSERT_NEXT(a_clear_empties, clk, rst,
    acc && (req.kind == scml_pkg::KIND_CLEAR), fill_count == '0)
  `SCML_ASSERT_NEXT(a_full_drop_keeps, clk, rst,
    acc && (req.kind == scml_pkg::KIND_LOAD) && (fill_count == FULL_CNT),
    fill_count == FULL_CNT)
  `SCML_ASSERT_IMPL(a_miss_zero, clk, rst,
    rsp.valid && (rsp.status == scml_pkg::ST_MISS),
    (rsp.rank == '0) && (rsp.out_name == '0) && (rsp.out_channel == '0))

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// testbench of sorted_channel_map_lookup_core: loads, lookups and clears through the
// request channel are checked against a sorted table model kept here
// depends on scml_pkg, scml_if and the design files
module testbench;

  localparam int TABLE_DEPTH = 1024;
  localparam int HOLD_CYCLES = 3000;
  localparam int LIMIT_CYCLES = 400000;
  localparam int POOL_SIZE = 48;
  localparam logic [scml_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  // one request and one answer as the table sees them
  typedef struct {
    logic [scml_pkg::KIND_W-1:0] kind;
    logic [scml_pkg::KEY_W-1:0]  key;
    scml_pkg::rec_t              rec;
  } request_t;

  typedef struct {
    scml_pkg::status_t            status;
    logic [scml_pkg::RANK_W-1:0]  rank;
    scml_pkg::rec_t               rec;
    logic [scml_pkg::COUNT_W-1:0] count;
  } answer_t;

  logic clk = 1'b0;
  logic rst;

  scml_req_if req_ch ();
  scml_rsp_if rsp_ch ();

  sorted_channel_map_lookup_core #(
    .ENTRIES (TABLE_DEPTH)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // sorted table model
  logic [scml_pkg::KEY_W-1:0] map_keys [TABLE_DEPTH];
  scml_pkg::rec_t             map_recs [TABLE_DEPTH];
  int unsigned                map_fill = 0;

  request_t                   request_q[$];
  answer_t                    answer_q[$];
  logic [scml_pkg::KEY_W-1:0] key_pool[$];
  request_t                   on_wire;
  answer_t                    oldest;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int results_seen = 0;
  int err_count = 0;

  always #6 clk = ~clk;

  // apply one request to the table model and return its answer
  function automatic answer_t apply_to_map(input request_t r);
    answer_t     a;
    int unsigned pos;
    a.status = scml_pkg::ST_OK;
    a.rank   = '0;
    a.rec    = '0;
    case (r.kind)
      scml_pkg::KIND_CLEAR: begin
        map_fill = 0;
      end
      scml_pkg::KIND_LOAD: begin
        if (map_fill >= TABLE_DEPTH) begin
          a.status = scml_pkg::ST_FULL;
        end else begin
          // shift larger keys up; equal keys stay ahead of the new entry
          pos = map_fill;
          while (pos > 0 && map_keys[pos-1] > r.key) begin
            map_keys[pos] = map_keys[pos-1];
            map_recs[pos] = map_recs[pos-1];
            pos--;
          end
          map_keys[pos] = r.key;
          map_recs[pos] = r.rec;
          map_fill++;
          a.rank = pos[scml_pkg::RANK_W-1:0];
        end
      end
      scml_pkg::KIND_LOOKUP: begin
        // first entry whose key is not below the searched key
        pos = 0;
        while (pos < map_fill && map_keys[pos] < r.key) pos++;
        if (pos < map_fill && map_keys[pos] == r.key) begin
          a.rank = pos[scml_pkg::RANK_W-1:0];
          a.rec  = map_recs[pos];
        end else begin
          a.status = scml_pkg::ST_MISS;
        end
      end
      default: begin
      end
    endcase
    a.count = map_fill[scml_pkg::COUNT_W-1:0];
    return a;
  endfunction

  function automatic scml_pkg::rec_t rand_rec();
    scml_pkg::rec_t r;
    r.name    = $urandom;
    r.plane   = 16'($urandom);
    r.segment = 8'($urandom);
    r.channel = $urandom;
    return r;
  endfunction

  // reuse a recent key now and then, so that lookups hit and loads collide
  function automatic logic [scml_pkg::KEY_W-1:0] pick_key(input int reuse_pct);
    logic [scml_pkg::KEY_W-1:0] k;
    if (key_pool.size() != 0 && $urandom_range(99) < reuse_pct)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    k = $urandom;
    if ($urandom_range(2) == 0) begin
      case ($urandom_range(5))
        0: k[31:24] = 8'h00;
        1: k[31:24] = 8'hFF;
        2: k[23:16] = 8'h00;
        3: k[23:16] = 8'hFF;
        4: k[15:0]  = 16'h0000;
        default: k[15:0] = 16'hFFFF;
      endcase
    end
    if (key_pool.size() < POOL_SIZE) key_pool = {key_pool, k};
    else key_pool[$urandom_range(POOL_SIZE - 1)] = k;
    return k;
  endfunction

  task automatic queue_item(input logic [scml_pkg::KIND_W-1:0] kind,
                            input logic [scml_pkg::KEY_W-1:0] key,
                            input scml_pkg::rec_t rec);
    request_t r;
    r.kind = kind;
    r.key  = key;
    r.rec  = rec;
    request_q = {request_q, r};
  endtask

  // mostly loads and lookups, with a few clears and unused kinds
  task automatic queue_random(input int n);
    int                          roll;
    logic [scml_pkg::KIND_W-1:0] kind;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 2) kind = scml_pkg::KIND_CLEAR;
      else if (roll < 4) kind = KIND_SPARE;
      else if (roll < 50) kind = scml_pkg::KIND_LOAD;
      else kind = scml_pkg::KIND_LOOKUP;
      queue_item(kind, pick_key(kind == scml_pkg::KIND_LOOKUP ? 70 : 25), rand_rec());
    end
  endtask

  // sender pause: every queued request sent and every answer back
  task automatic wait_quiet();
    while (request_q.size() != 0 || req_ch.valid || answer_q.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s at result %0d: got %0h, expected %0h",
             field, results_seen, got, want);
    err_count++;
  endtask

  // request driver: a transfer is predicted when it is taken
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= '0;
      req_ch.ip_third    <= '0;
      req_ch.ip_fourth   <= '0;
      req_ch.fe_chan     <= '0;
      req_ch.rec_name    <= '0;
      req_ch.rec_plane   <= '0;
      req_ch.rec_segment <= '0;
      req_ch.rec_channel <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) answer_q = {answer_q, apply_to_map(on_wire)};
      if (!req_ch.valid || req_ch.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = request_q.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.kind        <= on_wire.kind;
          req_ch.ip_third    <= on_wire.key[31:24];
          req_ch.ip_fourth   <= on_wire.key[23:16];
          req_ch.fe_chan     <= on_wire.key[15:0];
          req_ch.rec_name    <= on_wire.rec.name;
          req_ch.rec_plane   <= on_wire.rec.plane;
          req_ch.rec_segment <= on_wire.rec.segment;
          req_ch.rec_channel <= on_wire.rec.channel;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // response monitor: each transfer against the oldest answer
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result with no request pending", 64'(rsp_ch.status), '0);
        end else begin
          oldest = answer_q.pop_front();
          if (rsp_ch.status !== oldest.status)
            report_mismatch("status", 64'(rsp_ch.status), 64'(oldest.status));
          if (rsp_ch.rank !== oldest.rank)
            report_mismatch("rank", 64'(rsp_ch.rank), 64'(oldest.rank));
          if (rsp_ch.out_name !== oldest.rec.name)
            report_mismatch("out_name", 64'(rsp_ch.out_name), 64'(oldest.rec.name));
          if (rsp_ch.out_plane !== oldest.rec.plane)
            report_mismatch("out_plane", 64'(rsp_ch.out_plane), 64'(oldest.rec.plane));
          if (rsp_ch.out_segment !== oldest.rec.segment)
            report_mismatch("out_segment", 64'(rsp_ch.out_segment),
                            64'(oldest.rec.segment));
          if (rsp_ch.out_channel !== oldest.rec.channel)
            report_mismatch("out_channel", 64'(rsp_ch.out_channel),
                            64'(oldest.rec.channel));
          if (rsp_ch.entry_count !== oldest.count)
            report_mismatch("entry_count", 64'(rsp_ch.entry_count), 64'(oldest.count));
        end
        results_seen++;
      end
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver heavily
    send_idle_pct = 25;
    recv_idle_pct = 82;

    // directed: empty table, unused kind, extreme keys and records, duplicates
    queue_item(scml_pkg::KIND_LOOKUP, 32'h8040_1234, rand_rec());
    queue_item(scml_pkg::KIND_CLEAR, 32'h0000_0000, '0);
    queue_item(KIND_SPARE, 32'hFFFF_FFFF, '1);
    queue_item(scml_pkg::KIND_LOAD, 32'h0000_0000, '0);
    queue_item(scml_pkg::KIND_LOAD, 32'hFFFF_FFFF, '1);
    queue_item(scml_pkg::KIND_LOAD, 32'hFFFF_FFFF, rand_rec());
    queue_item(scml_pkg::KIND_LOAD, 32'h8040_1234, rand_rec());
    queue_item(scml_pkg::KIND_LOAD, 32'h0000_0000, rand_rec());
    queue_item(scml_pkg::KIND_LOOKUP, 32'h0000_0000, rand_rec());
    queue_item(scml_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, '0);
    queue_item(scml_pkg::KIND_LOOKUP, 32'h8040_1234, '1);
    queue_item(scml_pkg::KIND_LOOKUP, 32'h8040_1235, rand_rec());
    queue_item(KIND_SPARE, 32'h1234_5678, rand_rec());
    queue_item(scml_pkg::KIND_CLEAR, 32'hFFFF_FFFF, '1);
    queue_item(scml_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, rand_rec());
    queue_item(scml_pkg::KIND_LOAD, 32'h8040_1234, rand_rec());
    queue_item(scml_pkg::KIND_LOOKUP, 32'h8040_1234, rand_rec());
    queue_random(230);
    wait_quiet();

    // roles swapped; the receiver also holds off long enough that the first
    // result blocks the chain while the slow sender is still offering items
    send_idle_pct = 82;
    recv_idle_pct = 25;
    @(posedge clk);
    hold_asks <= hold_asks + 1;
    queue_random(250);
    wait_quiet();

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(250);
    wait_quiet();

    // let any stray result surface
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (answer_q.size() != 0)
      report_mismatch("answers never returned", 64'(answer_q.size()), '0);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
